// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the im2col checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, quiet while reset is high.
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/im2col_pkg.sv =====
// ---------------------------------------------------------------------------
// im2col package
// Types, register indexes and defaults shared by the im2col address generator.
// ---------------------------------------------------------------------------
`default_nettype none

package im2col_pkg;

  localparam int DEF_MAX_PLANES  = 512;
  localparam int DEF_MAX_KERNEL  = 11;
  localparam int DEF_MAX_SIDE    = 2048;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_WIDTH,
    REG_KERNEL_HEIGHT,
    REG_STRIDE_X,
    REG_STRIDE_Y,
    REG_PAD_X,
    REG_PAD_Y,
    REG_INPUT_WIDTH,
    REG_INPUT_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]  kernel_width;
    logic [3:0]  kernel_height;
    logic [3:0]  stride_x;
    logic [3:0]  stride_y;
    logic [2:0]  pad_x;
    logic [2:0]  pad_y;
    logic [11:0] input_width;
    logic [11:0] input_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kernel_width:  4'd3,
    kernel_height: 4'd3,
    stride_x:      4'd1,
    stride_y:      4'd1,
    pad_x:         3'd0,
    pad_y:         3'd0,
    input_width:   12'd1,
    input_height:  12'd1
  };

  typedef struct packed {
    logic        restart;
    logic [9:0]  plane_count;
    logic [11:0] out_cols;
    logic [11:0] out_rows;
  } item_t;

  typedef struct packed {
    logic [30:0] src_offset;
    logic [39:0] dst_offset;
    logic        zero_fill;
    logic        last;
  } result_t;

  typedef enum logic {
    KIND_STEP,
    KIND_RESTART
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  plane_count;
    logic [11:0] out_cols;
    logic [11:0] out_rows;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/im2col_front.sv =====
// ---------------------------------------------------------------------------
// im2col front end
// Holds the configuration registers, accepts items and tags them as restart
// or step entries for the command queue.
// ---------------------------------------------------------------------------
`default_nettype none

module im2col_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire im2col_pkg::item_t                   item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [im2col_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  output im2col_pkg::cfg_t                         cfg,
  output logic                                     push,
  output im2col_pkg::entry_t                       push_entry,
  input  wire logic                                full
);
  import im2col_pkg::*;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign push       = item_valid && !full;

  always_comb begin
    push_entry.kind        = item.restart ? KIND_RESTART : KIND_STEP;
    push_entry.plane_count = item.plane_count;
    push_entry.out_cols    = item.out_cols;
    push_entry.out_rows    = item.out_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[3:0];
        REG_STRIDE_X:      cfg.stride_x      <= cfg_data[3:0];
        REG_STRIDE_Y:      cfg.stride_y      <= cfg_data[3:0];
        REG_PAD_X:         cfg.pad_x         <= cfg_data[2:0];
        REG_PAD_Y:         cfg.pad_y         <= cfg_data[2:0];
        REG_INPUT_WIDTH:   cfg.input_width   <= cfg_data[11:0];
        REG_INPUT_HEIGHT:  cfg.input_height  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/im2col_fifo.sv =====
// ---------------------------------------------------------------------------
// im2col command queue
// Short first-in first-out queue of entries between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module im2col_fifo #(
  parameter int DEPTH = im2col_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire im2col_pkg::entry_t  push_entry,
  output logic                     full,
  input  wire logic                pop,
  output im2col_pkg::entry_t       pop_entry,
  output logic                     not_empty
);
  import im2col_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/im2col_back.sv =====
// ---------------------------------------------------------------------------
// im2col back end
// Walks the unfold counters and forms source and destination offsets in two
// steps: coordinates and plane row base, then row times width plus column.
// ---------------------------------------------------------------------------
`default_nettype none

module im2col_back #(
  parameter int MAX_PLANES = im2col_pkg::DEF_MAX_PLANES,
  parameter int MAX_KERNEL = im2col_pkg::DEF_MAX_KERNEL,
  parameter int MAX_SIDE   = im2col_pkg::DEF_MAX_SIDE
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire im2col_pkg::cfg_t    cfg,
  input  wire logic                entry_valid,
  input  wire im2col_pkg::entry_t  entry,
  output logic                     pop,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output im2col_pkg::result_t      result
);
  import im2col_pkg::*;

  localparam int PL_W = $clog2(MAX_PLANES + 1);
  localparam int KI_W = $clog2(MAX_KERNEL + 1);
  localparam int SD_W = $clog2(MAX_SIDE + 1);
  localparam int CO_W = SD_W + 6;
  localparam int PH_W = PL_W + SD_W;
  localparam int SR_W = PH_W + SD_W;

  typedef enum logic {S_TAKE, S_ADDR} state_t;

  state_t            state;
  logic              running;
  logic [PL_W-1:0]   plane_idx;
  logic [KI_W-1:0]   krow_idx;
  logic [KI_W-1:0]   kcol_idx;
  logic [SD_W-1:0]   orow_idx;
  logic [SD_W-1:0]   ocol_idx;
  logic [39:0]       dst_count;
  logic [PL_W-1:0]   saved_planes;
  logic [SD_W-1:0]   saved_out_cols;
  logic [SD_W-1:0]   saved_out_rows;

  logic [PH_W-1:0]   plane_h_q;
  logic [SD_W-1:0]   iy_q;
  logic [SD_W-1:0]   ix_q;
  logic              fill_q;
  logic              fin_q;
  logic [39:0]       dst_q;

  logic [KI_W-1:0]   kw;
  logic [KI_W-1:0]   kh;
  logic [3:0]        sx;
  logic [3:0]        sy;
  logic [SD_W-1:0]   w;
  logic [SD_W-1:0]   h;
  logic [PL_W-1:0]   planes_in;
  logic [SD_W-1:0]   cols_in;
  logic [SD_W-1:0]   rows_in;

  logic [CO_W-1:0]   iy;
  logic [CO_W-1:0]   ix;
  logic              fill;
  logic [PH_W-1:0]   plane_h;
  logic [PL_W:0]     plane_inc;
  logic [KI_W:0]     krow_inc;
  logic [KI_W:0]     kcol_inc;
  logic [SD_W:0]     orow_inc;
  logic [SD_W:0]     ocol_inc;
  logic              plane_end;
  logic              krow_end;
  logic              kcol_end;
  logic              orow_end;
  logic              ocol_end;
  logic              fin;
  logic [PH_W-1:0]   row_q;
  logic [SR_W-1:0]   src_full;
  logic              out_free;

  always_comb begin
    if (cfg.kernel_width == 4'd0) begin
      kw = KI_W'(1);
    end else if (32'(cfg.kernel_width) > 32'(MAX_KERNEL)) begin
      kw = KI_W'(MAX_KERNEL);
    end else begin
      kw = KI_W'(cfg.kernel_width);
    end
    if (cfg.kernel_height == 4'd0) begin
      kh = KI_W'(1);
    end else if (32'(cfg.kernel_height) > 32'(MAX_KERNEL)) begin
      kh = KI_W'(MAX_KERNEL);
    end else begin
      kh = KI_W'(cfg.kernel_height);
    end
    sx = (cfg.stride_x == 4'd0) ? 4'd1 : cfg.stride_x;
    sy = (cfg.stride_y == 4'd0) ? 4'd1 : cfg.stride_y;
    if (cfg.input_width == 12'd0) begin
      w = SD_W'(1);
    end else if (32'(cfg.input_width) > 32'(MAX_SIDE)) begin
      w = SD_W'(MAX_SIDE);
    end else begin
      w = SD_W'(cfg.input_width);
    end
    if (cfg.input_height == 12'd0) begin
      h = SD_W'(1);
    end else if (32'(cfg.input_height) > 32'(MAX_SIDE)) begin
      h = SD_W'(MAX_SIDE);
    end else begin
      h = SD_W'(cfg.input_height);
    end
    if (entry.plane_count == 10'd0) begin
      planes_in = PL_W'(1);
    end else if (32'(entry.plane_count) > 32'(MAX_PLANES)) begin
      planes_in = PL_W'(MAX_PLANES);
    end else begin
      planes_in = PL_W'(entry.plane_count);
    end
    if (entry.out_cols == 12'd0) begin
      cols_in = SD_W'(1);
    end else if (32'(entry.out_cols) > 32'(MAX_SIDE)) begin
      cols_in = SD_W'(MAX_SIDE);
    end else begin
      cols_in = SD_W'(entry.out_cols);
    end
    if (entry.out_rows == 12'd0) begin
      rows_in = SD_W'(1);
    end else if (32'(entry.out_rows) > 32'(MAX_SIDE)) begin
      rows_in = SD_W'(MAX_SIDE);
    end else begin
      rows_in = SD_W'(entry.out_rows);
    end
  end

  // Negative coordinates wrap to large unsigned values and land in padding.
  always_comb begin
    iy = CO_W'(orow_idx) * CO_W'(sy) + CO_W'(krow_idx) - CO_W'(cfg.pad_y);
    ix = CO_W'(ocol_idx) * CO_W'(sx) + CO_W'(kcol_idx) - CO_W'(cfg.pad_x);
    fill    = (iy >= CO_W'(h)) || (ix >= CO_W'(w));
    plane_h = PH_W'(plane_idx) * PH_W'(h);

    plane_inc = (PL_W+1)'(plane_idx) + (PL_W+1)'(1);
    krow_inc  = (KI_W+1)'(krow_idx) + (KI_W+1)'(1);
    kcol_inc  = (KI_W+1)'(kcol_idx) + (KI_W+1)'(1);
    orow_inc  = (SD_W+1)'(orow_idx) + (SD_W+1)'(1);
    ocol_inc  = (SD_W+1)'(ocol_idx) + (SD_W+1)'(1);
    plane_end = plane_inc >= (PL_W+1)'(saved_planes);
    krow_end  = krow_inc >= (KI_W+1)'(kh);
    kcol_end  = kcol_inc >= (KI_W+1)'(kw);
    orow_end  = orow_inc >= (SD_W+1)'(saved_out_rows);
    ocol_end  = ocol_inc >= (SD_W+1)'(saved_out_cols);
    fin       = plane_end && krow_end && kcol_end && orow_end && ocol_end;
  end

  always_comb begin
    row_q    = plane_h_q + PH_W'(iy_q);
    src_full = SR_W'(row_q) * SR_W'(w) + SR_W'(ix_q);
  end

  assign pop      = (state == S_TAKE) && entry_valid;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_TAKE;
      running        <= 1'b0;
      result_valid   <= 1'b0;
      plane_idx      <= '0;
      krow_idx       <= '0;
      kcol_idx       <= '0;
      orow_idx       <= '0;
      ocol_idx       <= '0;
      dst_count      <= '0;
      saved_planes   <= PL_W'(1);
      saved_out_cols <= SD_W'(1);
      saved_out_rows <= SD_W'(1);
    end else begin
      if (result_valid && !result_stall && state != S_ADDR) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_TAKE: begin
          if (entry_valid) begin
            if (entry.kind == KIND_RESTART) begin
              saved_planes   <= planes_in;
              saved_out_cols <= cols_in;
              saved_out_rows <= rows_in;
              plane_idx      <= '0;
              krow_idx       <= '0;
              kcol_idx       <= '0;
              orow_idx       <= '0;
              ocol_idx       <= '0;
              dst_count      <= '0;
              running        <= 1'b1;
            end else if (running) begin
              plane_h_q <= plane_h;
              iy_q      <= iy[SD_W-1:0];
              ix_q      <= ix[SD_W-1:0];
              fill_q    <= fill;
              fin_q     <= fin;
              dst_q     <= dst_count;
              dst_count <= dst_count + 40'd1;
              state     <= S_ADDR;
              if (fin) begin
                running <= 1'b0;
              end else if (ocol_end) begin
                ocol_idx <= '0;
                if (orow_end) begin
                  orow_idx <= '0;
                  if (kcol_end) begin
                    kcol_idx <= '0;
                    if (krow_end) begin
                      krow_idx  <= '0;
                      plane_idx <= plane_end ? '0 : plane_inc[PL_W-1:0];
                    end else begin
                      krow_idx <= krow_inc[KI_W-1:0];
                    end
                  end else begin
                    kcol_idx <= kcol_inc[KI_W-1:0];
                  end
                end else begin
                  orow_idx <= orow_inc[SD_W-1:0];
                end
              end else begin
                ocol_idx <= ocol_inc[SD_W-1:0];
              end
            end
          end
        end
        S_ADDR: begin
          if (out_free) begin
            result.src_offset <= fill_q ? '0 : 31'(src_full);
            result.dst_offset <= dst_q;
            result.zero_fill  <= fill_q;
            result.last       <= fin_q;
            result_valid      <= 1'b1;
            state             <= S_TAKE;
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/im2col_address_generator_top.sv =====
// ---------------------------------------------------------------------------
// im2col address generator
// Emits the unfold sequence of a 2-D convolution, one element per step item of a running unfold.
// ---------------------------------------------------------------------------
// A restart item latches plane count and output sizes; each later step item
// yields one element (source offset or zero fill, destination offset, last
// mark) until the element marked last, after which step items are dropped
// until the next restart. Items pass through a two-entry queue, so the input
// side keeps accepting while the back end works, until the queue is full. The
// back end forms each element in two steps: first the coordinates and the
// plane base, then the row-times-width multiply and column add; a restart or
// a dropped step is handled in the take state alone. A result register holds
// a finished element while the next one is being computed, so the back end
// starts on the next element before the last is taken. There is no clearing pass after reset.
`default_nettype none

module im2col_address_generator_top #(
  parameter int MAX_PLANES  = im2col_pkg::DEF_MAX_PLANES,
  parameter int MAX_KERNEL  = im2col_pkg::DEF_MAX_KERNEL,
  parameter int MAX_SIDE    = im2col_pkg::DEF_MAX_SIDE,
  parameter int QUEUE_DEPTH = im2col_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire im2col_pkg::item_t                   item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [im2col_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output im2col_pkg::result_t                      result
);
  import im2col_pkg::*;

  cfg_t    cfg;
  logic    push;
  entry_t  push_entry;
  logic    full;
  logic    pop;
  entry_t  pop_entry;
  logic    not_empty;

  im2col_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  im2col_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (not_empty)
  );

  im2col_back #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_SIDE   (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .entry_valid  (not_empty),
    .entry        (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/im2col_checker.sv =====
// ---------------------------------------------------------------------------
// im2col checker
// Port-level assertions on the result channel of the address generator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module im2col_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire im2col_pkg::result_t  result
);
  import im2col_pkg::*;

  logic [39:0] prev_dst;
  logic        have_prev;
  logic        after_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dst   <= '0;
      have_prev  <= 1'b0;
      after_last <= 1'b0;
    end else if (result_valid && !result_stall) begin
      prev_dst   <= result.dst_offset;
      have_prev  <= 1'b1;
      after_last <= result.last;
    end
  end

  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !result_valid, "result valid after reset")
  `ASSERT_ON(a_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `ASSERT_ON(a_fill_zero, clk, rst, result_valid && result.zero_fill |-> result.src_offset == 31'd0, "zero fill with nonzero source")
  `ASSERT_ON(a_dst_seq, clk, rst, result_valid && have_prev && result.dst_offset != 40'd0 |-> result.dst_offset == prev_dst + 40'd1, "destination offset out of sequence")
  `ASSERT_ON(a_new_unfold, clk, rst, result_valid && after_last |-> result.dst_offset == 40'd0, "element after last not at start")

endmodule

bind im2col_address_generator_top im2col_checker u_checker (.*);

`default_nettype wire
